// ----- rtl/vrp_pkg.sv -----
// shared types, constants and register codes for the view rotate and project block
package vrp_pkg;

    localparam int COORD_W   = 32;
    localparam int TRIG_W    = 16;
    localparam int TRIG_FRAC = 14;
    localparam int OPND_W    = COORD_W + 1;
    localparam int COEF_W    = TRIG_W + 1;
    localparam int PROD_W    = OPND_W + COEF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int FOCAL_W   = 31;
    localparam int NUM_W     = 2 * COORD_W;
    localparam int KIND_W    = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [KIND_W-1:0] KIND_YAW     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_YX_PROJ = 3'd1;
    localparam logic [KIND_W-1:0] KIND_XY_PROJ = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ROTATE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PROJECT = 3'd4;

    localparam logic [2:0] REG_VIEW_X = 3'd0;
    localparam logic [2:0] REG_VIEW_Y = 3'd1;
    localparam logic [2:0] REG_VIEW_Z = 3'd2;
    localparam logic [2:0] REG_ROT_X  = 3'd3;
    localparam logic [2:0] REG_ROT_Y  = 3'd4;
    localparam logic [2:0] REG_ROT_Z  = 3'd5;
    localparam logic [2:0] REG_FOCAL  = 3'd6;

    localparam logic [DATA_W-1:0] PAIR_RESET  = 32'h4000_0000;
    localparam logic [FOCAL_W-1:0] FOCAL_RESET = 31'd32768;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic                      st;
    } side_t;

    typedef struct packed {
        logic dz_a;
        logic dz_b;
        logic sat_a;
        logic sat_b;
    } div_flags_t;

endpackage

// ----- rtl/vrp_rot.sv -----
// two-stage rotation unit: two sums of products, rounded, shifted and saturated
module vrp_rot (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vrp_pkg::OPND_W-1:0]   u,
    input  logic signed [vrp_pkg::OPND_W-1:0]   v,
    input  logic signed [vrp_pkg::COEF_W-1:0]   k11,
    input  logic signed [vrp_pkg::COEF_W-1:0]   k12,
    input  logic signed [vrp_pkg::COEF_W-1:0]   k21,
    input  logic signed [vrp_pkg::COEF_W-1:0]   k22,
    output logic signed [vrp_pkg::COORD_W-1:0]  r1,
    output logic signed [vrp_pkg::COORD_W-1:0]  r2,
    output logic                                f1,
    output logic                                f2
);

    localparam logic signed [vrp_pkg::SUM_W-1:0] ROUND =
        vrp_pkg::SUM_W'(1) <<< (vrp_pkg::TRIG_FRAC - 1);
    localparam logic signed [vrp_pkg::SUM_W-1:0] HI = vrp_pkg::SUM_W'(vrp_pkg::COORD_MAX);
    localparam logic signed [vrp_pkg::SUM_W-1:0] LO = vrp_pkg::SUM_W'(vrp_pkg::COORD_MIN);

    logic signed [vrp_pkg::PROD_W-1:0]  p11_reg, p12_reg, p21_reg, p22_reg;
    logic signed [vrp_pkg::SUM_W-1:0]   s1, s2, sh1, sh2;
    logic signed [vrp_pkg::COORD_W-1:0] r1_next, r2_next;
    logic                               f1_next, f2_next;
    logic signed [vrp_pkg::COORD_W-1:0] r1_reg, r2_reg;
    logic                               f1_reg, f2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p11_reg <= u * k11;
            p12_reg <= v * k12;
            p21_reg <= u * k21;
            p22_reg <= v * k22;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
            f1_reg  <= f1_next;
            f2_reg  <= f2_next;
        end
    end

    always_comb
    begin
        s1  = vrp_pkg::SUM_W'(p11_reg) + vrp_pkg::SUM_W'(p12_reg) + ROUND;
        s2  = vrp_pkg::SUM_W'(p21_reg) + vrp_pkg::SUM_W'(p22_reg) + ROUND;
        sh1 = s1 >>> vrp_pkg::TRIG_FRAC;
        sh2 = s2 >>> vrp_pkg::TRIG_FRAC;
        f1_next = 1'b0;
        f2_next = 1'b0;
        if (sh1 > HI)
        begin
            r1_next = vrp_pkg::COORD_MAX;
            f1_next = 1'b1;
        end
        else if (sh1 < LO)
        begin
            r1_next = vrp_pkg::COORD_MIN;
            f1_next = 1'b1;
        end
        else
        begin
            r1_next = sh1[vrp_pkg::COORD_W-1:0];
        end
        if (sh2 > HI)
        begin
            r2_next = vrp_pkg::COORD_MAX;
            f2_next = 1'b1;
        end
        else if (sh2 < LO)
        begin
            r2_next = vrp_pkg::COORD_MIN;
            f2_next = 1'b1;
        end
        else
        begin
            r2_next = sh2[vrp_pkg::COORD_W-1:0];
        end
    end

    assign r1 = r1_reg;
    assign r2 = r2_reg;
    assign f1 = f1_reg;
    assign f2 = f2_reg;

endmodule

// ----- rtl/vrp_div.sv -----
// focal scaling and two-lane pipelined restoring divider, one quotient bit per stage
module vrp_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_v,
    input  logic signed [vrp_pkg::COORD_W-1:0]  num_a,
    input  logic signed [vrp_pkg::COORD_W-1:0]  num_b,
    input  logic signed [vrp_pkg::COORD_W-1:0]  den,
    input  logic [vrp_pkg::FOCAL_W-1:0]         focal,
    input  vrp_pkg::side_t                      side_in,
    output logic                                out_v,
    output logic signed [vrp_pkg::COORD_W-1:0]  q_a,
    output logic signed [vrp_pkg::COORD_W-1:0]  q_b,
    output vrp_pkg::div_flags_t                 flags,
    output vrp_pkg::side_t                      side_out
);

    localparam int CW    = vrp_pkg::COORD_W;
    localparam int NW    = vrp_pkg::NUM_W;
    localparam int STEPS = CW;
    localparam logic [CW-1:0] POS_LIM = CW'(vrp_pkg::COORD_MAX);
    localparam logic [CW-1:0] NEG_LIM = CW'(vrp_pkg::COORD_MIN);

    // scaling stage
    logic signed [NW-1:0]  na_reg, nb_reg;
    logic signed [CW-1:0]  d_reg;
    vrp_pkg::side_t        m_side_reg;
    logic                  m_v_reg;

    // magnitude stage and iteration stages
    logic [CW-1:0]   rem_a [STEPS+1];
    logic [CW-1:0]   rem_b [STEPS+1];
    logic [CW-1:0]   w_a   [STEPS+1];
    logic [CW-1:0]   w_b   [STEPS+1];
    logic [CW-1:0]   dm    [STEPS+1];
    logic [5:0]      fl    [STEPS+1];   // ovf_a, neg_a, nz_a, ovf_b, neg_b, nz_b
    logic            dz    [STEPS+1];
    vrp_pkg::side_t  sd    [STEPS+1];
    logic            vv    [STEPS+1];

    logic signed [NW-1:0]  na_next, nb_next;
    logic [NW-1:0]         mag_a, mag_b;
    logic signed [CW:0]    dext;
    logic [CW:0]           dmag;

    assign na_next = num_a * $signed({1'b0, focal});
    assign nb_next = num_b * $signed({1'b0, focal});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else if (en)
        begin
            m_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg     <= na_next;
            nb_reg     <= nb_next;
            d_reg      <= den;
            m_side_reg <= side_in;
        end
    end

    always_comb
    begin
        mag_a = na_reg[NW-1] ? NW'(-na_reg) : NW'(na_reg);
        mag_b = nb_reg[NW-1] ? NW'(-nb_reg) : NW'(nb_reg);
        dext  = (CW+1)'(d_reg);
        dmag  = dext[CW] ? (CW+1)'(-dext) : (CW+1)'(dext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv[0] <= 1'b0;
        end
        else if (en)
        begin
            vv[0] <= m_v_reg;
        end
    end

    // quotient sign is the numerator sign when the divisor is zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_a[0] <= mag_a[NW-1:CW];
            rem_b[0] <= mag_b[NW-1:CW];
            w_a[0]   <= mag_a[CW-1:0];
            w_b[0]   <= mag_b[CW-1:0];
            dm[0]    <= dmag[CW-1:0];
            dz[0]    <= (d_reg == '0);
            fl[0]    <= {(mag_a[NW-1:CW] >= dmag[CW-1:0]), na_reg[NW-1] ^ d_reg[CW-1],
                         (na_reg != '0),
                         (mag_b[NW-1:CW] >= dmag[CW-1:0]), nb_reg[NW-1] ^ d_reg[CW-1],
                         (nb_reg != '0)};
            sd[0]    <= m_side_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic [CW:0] ta, tb;
            logic        ge_a, ge_b;

            always_comb
            begin
                ta   = {rem_a[k], w_a[k][CW-1]};
                tb   = {rem_b[k], w_b[k][CW-1]};
                ge_a = (ta >= {1'b0, dm[k]});
                ge_b = (tb >= {1'b0, dm[k]});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vv[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    vv[k+1] <= vv[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_a[k+1] <= ge_a ? CW'(ta - {1'b0, dm[k]}) : ta[CW-1:0];
                    rem_b[k+1] <= ge_b ? CW'(tb - {1'b0, dm[k]}) : tb[CW-1:0];
                    w_a[k+1]   <= {w_a[k][CW-2:0], ge_a};
                    w_b[k+1]   <= {w_b[k][CW-2:0], ge_b};
                    dm[k+1]    <= dm[k];
                    dz[k+1]    <= dz[k];
                    fl[k+1]    <= fl[k];
                    sd[k+1]    <= sd[k];
                end
            end
        end
    endgenerate

    // sign, saturation and zero-divisor handling
    logic signed [CW-1:0] qa_next, qb_next;
    logic                 sa_next, sb_next;
    logic signed [CW-1:0] qa_reg, qb_reg;
    vrp_pkg::div_flags_t  flags_reg;
    vrp_pkg::side_t       side_reg;
    logic                 out_v_reg;

    always_comb
    begin
        sa_next = 1'b0;
        sb_next = 1'b0;
        if (dz[STEPS])
        begin
            qa_next = !fl[STEPS][3] ? '0 : (fl[STEPS][4] ? vrp_pkg::COORD_MIN : vrp_pkg::COORD_MAX);
            qb_next = !fl[STEPS][0] ? '0 : (fl[STEPS][1] ? vrp_pkg::COORD_MIN : vrp_pkg::COORD_MAX);
        end
        else
        begin
            if (fl[STEPS][5] || (!fl[STEPS][4] && w_a[STEPS] > POS_LIM)
                || (fl[STEPS][4] && w_a[STEPS] > NEG_LIM))
            begin
                sa_next = 1'b1;
                qa_next = fl[STEPS][4] ? vrp_pkg::COORD_MIN : vrp_pkg::COORD_MAX;
            end
            else
            begin
                qa_next = fl[STEPS][4] ? -$signed(w_a[STEPS]) : $signed(w_a[STEPS]);
            end
            if (fl[STEPS][2] || (!fl[STEPS][1] && w_b[STEPS] > POS_LIM)
                || (fl[STEPS][1] && w_b[STEPS] > NEG_LIM))
            begin
                sb_next = 1'b1;
                qb_next = fl[STEPS][1] ? vrp_pkg::COORD_MIN : vrp_pkg::COORD_MAX;
            end
            else
            begin
                qb_next = fl[STEPS][1] ? -$signed(w_b[STEPS]) : $signed(w_b[STEPS]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= vv[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qa_reg          <= qa_next;
            qb_reg          <= qb_next;
            flags_reg.dz_a  <= dz[STEPS];
            flags_reg.dz_b  <= dz[STEPS];
            flags_reg.sat_a <= sa_next;
            flags_reg.sat_b <= sb_next;
            side_reg        <= sd[STEPS];
        end
    end

    assign out_v    = out_v_reg;
    assign q_a      = qa_reg;
    assign q_b      = qb_reg;
    assign flags    = flags_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/view_rotate_and_project.sv -----
// top level: configuration registers, two rotation units, projection divider, output register
//
// Fully pipelined: one word is accepted per cycle while the output is not stalled. Each word
// passes the input stage, the two rotation units and the 32 one-bit stages of the perspective
// divider. The whole pipe advances together; a stalled output holds every stage and raises
// in_stall. Configuration must only be written while no word is in flight.
module view_rotate_and_project (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vrp_pkg::ADDR_W-1:0]          paddr,
    input  logic [vrp_pkg::DATA_W-1:0]          pwdata,
    output logic [vrp_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [vrp_pkg::KIND_W-1:0]          kind,
    input  logic signed [vrp_pkg::COORD_W-1:0]  in_x,
    input  logic signed [vrp_pkg::COORD_W-1:0]  in_y,
    input  logic signed [vrp_pkg::COORD_W-1:0]  in_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vrp_pkg::COORD_W-1:0]  out_a,
    output logic signed [vrp_pkg::COORD_W-1:0]  out_b,
    output logic signed [vrp_pkg::COORD_W-1:0]  out_c,
    output logic                                depth_zero,
    output logic                                saturated
);

    localparam int CW = vrp_pkg::COORD_W;
    localparam int OW = vrp_pkg::OPND_W;
    localparam int KW = vrp_pkg::COEF_W;

    // configuration
    logic signed [CW-1:0]              vpx_reg, vpy_reg, vpz_reg;
    logic [vrp_pkg::DATA_W-1:0]        rx_reg, ry_reg, rz_reg;
    logic [vrp_pkg::FOCAL_W-1:0]       focal_reg;
    logic [2:0]                        reg_idx;
    logic                              wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpx_reg   <= '0;
            vpy_reg   <= '0;
            vpz_reg   <= '0;
            rx_reg    <= vrp_pkg::PAIR_RESET;
            ry_reg    <= vrp_pkg::PAIR_RESET;
            rz_reg    <= vrp_pkg::PAIR_RESET;
            focal_reg <= vrp_pkg::FOCAL_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                vrp_pkg::REG_VIEW_X: vpx_reg   <= pwdata;
                vrp_pkg::REG_VIEW_Y: vpy_reg   <= pwdata;
                vrp_pkg::REG_VIEW_Z: vpz_reg   <= pwdata;
                vrp_pkg::REG_ROT_X:  rx_reg    <= pwdata;
                vrp_pkg::REG_ROT_Y:  ry_reg    <= pwdata;
                vrp_pkg::REG_ROT_Z:  rz_reg    <= pwdata;
                vrp_pkg::REG_FOCAL:  focal_reg <= pwdata[vrp_pkg::FOCAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            vrp_pkg::REG_VIEW_X: prdata = vpx_reg;
            vrp_pkg::REG_VIEW_Y: prdata = vpy_reg;
            vrp_pkg::REG_VIEW_Z: prdata = vpz_reg;
            vrp_pkg::REG_ROT_X:  prdata = rx_reg;
            vrp_pkg::REG_ROT_Y:  prdata = ry_reg;
            vrp_pkg::REG_ROT_Z:  prdata = rz_reg;
            vrp_pkg::REG_FOCAL:  prdata = {1'b0, focal_reg};
            default:             prdata = '0;
        endcase
    end

    // trig halves, with negated forms
    logic signed [KW-1:0] cx, sx, cy, sy, cz, sz, nsx, nsy, nsz;

    always_comb
    begin
        cx  = KW'($signed(rx_reg[31:16]));
        sx  = KW'($signed(rx_reg[15:0]));
        cy  = KW'($signed(ry_reg[31:16]));
        sy  = KW'($signed(ry_reg[15:0]));
        cz  = KW'($signed(rz_reg[31:16]));
        sz  = KW'($signed(rz_reg[15:0]));
        nsx = -sx;
        nsy = -sy;
        nsz = -sz;
    end

    // pipeline advance
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // input stage
    logic                      v0_reg;
    logic [vrp_pkg::KIND_W-1:0] k0_reg;
    logic signed [CW-1:0]      x0_reg, y0_reg, z0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k0_reg <= kind;
            x0_reg <= in_x;
            y0_reg <= in_y;
            z0_reg <= in_z;
        end
    end

    // first rotation operands
    logic signed [OW-1:0] dx, dy, d4, u1, w1;
    logic signed [KW-1:0] a11, a12, a21, a22;
    logic signed [CW-1:0] r4b;
    logic                 st4;

    always_comb
    begin
        dx  = OW'(x0_reg) - OW'(vpx_reg);
        dy  = OW'(y0_reg) - OW'(vpy_reg);
        d4  = OW'(y0_reg) - OW'(vpz_reg);
        st4 = 1'b0;
        if (d4 > OW'(vrp_pkg::COORD_MAX))
        begin
            r4b = vrp_pkg::COORD_MAX;
            st4 = 1'b1;
        end
        else if (d4 < OW'(vrp_pkg::COORD_MIN))
        begin
            r4b = vrp_pkg::COORD_MIN;
            st4 = 1'b1;
        end
        else
        begin
            r4b = d4[CW-1:0];
        end
        case (k0_reg)
            vrp_pkg::KIND_YAW:
            begin
                u1 = dx; w1 = dy;
                a11 = cz; a12 = sz; a21 = nsz; a22 = cz;
            end
            vrp_pkg::KIND_YX_PROJ:
            begin
                u1 = OW'(y0_reg); w1 = OW'(z0_reg);
                a11 = cx; a12 = nsx; a21 = sx; a22 = cx;
            end
            vrp_pkg::KIND_XY_PROJ:
            begin
                u1 = OW'(x0_reg); w1 = OW'(z0_reg);
                a11 = cy; a12 = sy; a21 = nsy; a22 = cy;
            end
            default:
            begin
                u1 = OW'(y0_reg); w1 = OW'(z0_reg);
                a11 = cx; a12 = sx; a21 = nsx; a22 = cx;
            end
        endcase
    end

    logic signed [CW-1:0] o1, o2;
    logic                 g1f1, g1f2;

    vrp_rot u_rot1 (
        .clk (clk), .en (adv), .u (u1), .v (w1),
        .k11 (a11), .k12 (a12), .k21 (a21), .k22 (a22),
        .r1 (o1), .r2 (o2), .f1 (g1f1), .f2 (g1f2)
    );

    // side registers alongside the first rotation
    logic                       v1_reg, v2_reg;
    logic [vrp_pkg::KIND_W-1:0] k1_reg, k2_reg;
    logic signed [CW-1:0]       x1_reg, x2_reg, y1_reg, y2_reg, z1_reg, z2_reg;
    logic signed [CW-1:0]       r4b1_reg, r4b2_reg;
    logic                       st41_reg, st42_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_reg   <= k0_reg;
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            z1_reg   <= z0_reg;
            r4b1_reg <= r4b;
            st41_reg <= st4;
            k2_reg   <= k1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            r4b2_reg <= r4b1_reg;
            st42_reg <= st41_reg;
        end
    end

    // second rotation operands and flags after the first rotation
    logic signed [OW-1:0] u2, w2;
    logic signed [KW-1:0] b11, b12, b21, b22;
    logic                 st_a;

    always_comb
    begin
        w2 = OW'(o2);
        case (k2_reg)
            vrp_pkg::KIND_YX_PROJ:
            begin
                u2 = OW'(x2_reg);
                b11 = cy; b12 = nsy; b21 = sy; b22 = cy;
            end
            vrp_pkg::KIND_XY_PROJ:
            begin
                u2 = OW'(y2_reg);
                b11 = cx; b12 = sx; b21 = nsx; b22 = cx;
            end
            default:
            begin
                u2 = OW'(x2_reg);
                b11 = cy; b12 = sy; b21 = nsy; b22 = cy;
            end
        endcase
        case (k2_reg)
            vrp_pkg::KIND_YAW, vrp_pkg::KIND_YX_PROJ,
            vrp_pkg::KIND_XY_PROJ, vrp_pkg::KIND_ROTATE: st_a = g1f1 | g1f2;
            vrp_pkg::KIND_PROJECT:                       st_a = st42_reg;
            default:                                     st_a = 1'b0;
        endcase
    end

    logic signed [CW-1:0] p1, p2;
    logic                 g2f1, g2f2;

    vrp_rot u_rot2 (
        .clk (clk), .en (adv), .u (u2), .v (w2),
        .k11 (b11), .k12 (b12), .k21 (b21), .k22 (b22),
        .r1 (p1), .r2 (p2), .f1 (g2f1), .f2 (g2f2)
    );

    // side registers alongside the second rotation
    logic                       v3_reg, v4_reg;
    logic [vrp_pkg::KIND_W-1:0] k3_reg, k4_reg;
    logic signed [CW-1:0]       x3_reg, x4_reg, z3_reg, z4_reg;
    logic signed [CW-1:0]       q13_reg, q14_reg, q23_reg, q24_reg, r4b3_reg, r4b4_reg;
    logic                       st3_reg, st4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k3_reg   <= k2_reg;
            x3_reg   <= x2_reg;
            z3_reg   <= z2_reg;
            q13_reg  <= o1;
            q23_reg  <= o2;
            r4b3_reg <= r4b2_reg;
            st3_reg  <= st_a;
            k4_reg   <= k3_reg;
            x4_reg   <= x3_reg;
            z4_reg   <= z3_reg;
            q14_reg  <= q13_reg;
            q24_reg  <= q23_reg;
            r4b4_reg <= r4b3_reg;
            st4_reg  <= st3_reg;
        end
    end

    // divider operands and words that bypass it
    logic signed [CW-1:0] na, nb, dd;
    vrp_pkg::side_t       side_in;

    always_comb
    begin
        na = '0;
        nb = '0;
        dd = '0;
        side_in.kind = k4_reg;
        side_in.a    = '0;
        side_in.b    = '0;
        side_in.c    = '0;
        side_in.st   = st4_reg;
        case (k4_reg)
            vrp_pkg::KIND_YAW:
            begin
                side_in.a = q14_reg;
                side_in.b = q24_reg;
            end
            vrp_pkg::KIND_YX_PROJ:
            begin
                na = p1; nb = p2; dd = q14_reg;
                side_in.st = st4_reg | g2f1 | g2f2;
            end
            vrp_pkg::KIND_XY_PROJ:
            begin
                na = q14_reg; nb = p2; dd = p1;
                side_in.st = st4_reg | g2f1 | g2f2;
            end
            vrp_pkg::KIND_ROTATE:
            begin
                side_in.a  = p1;
                side_in.b  = q14_reg;
                side_in.c  = p2;
                side_in.st = st4_reg | g2f1 | g2f2;
            end
            vrp_pkg::KIND_PROJECT:
            begin
                na = x4_reg; nb = r4b4_reg; dd = z4_reg;
            end
            default:
            begin
                side_in.st = 1'b0;
            end
        endcase
    end

    logic                 dv;
    logic signed [CW-1:0] qa, qb;
    vrp_pkg::div_flags_t  dfl;
    vrp_pkg::side_t       side_out;

    vrp_div u_div (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_v (v4_reg),
        .num_a (na), .num_b (nb), .den (dd), .focal (focal_reg),
        .side_in (side_in),
        .out_v (dv), .q_a (qa), .q_b (qb), .flags (dfl), .side_out (side_out)
    );

    // output register
    logic signed [CW-1:0] a_reg, b_reg, c_reg;
    logic                 dz_reg, sat_reg;
    logic signed [CW-1:0] a_next, b_next, c_next;
    logic                 dz_next, sat_next;

    always_comb
    begin
        case (side_out.kind)
            vrp_pkg::KIND_YX_PROJ, vrp_pkg::KIND_XY_PROJ, vrp_pkg::KIND_PROJECT:
            begin
                a_next   = qa;
                b_next   = qb;
                c_next   = '0;
                dz_next  = dfl.dz_a | dfl.dz_b;
                sat_next = side_out.st | dfl.sat_a | dfl.sat_b;
            end
            default:
            begin
                a_next   = side_out.a;
                b_next   = side_out.b;
                c_next   = side_out.c;
                dz_next  = 1'b0;
                sat_next = side_out.st;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            dz_reg  <= dz_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_a      = a_reg;
    assign out_b      = b_reg;
    assign out_c      = c_reg;
    assign depth_zero = dz_reg;
    assign saturated  = sat_reg;

`ifndef ASSERT_OFF
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v0_reg |=> v1_reg)
        else $error("word lost between input and rotation stages");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall ##1 (out_valid && $stable(out_a)))
        else $error("pipeline moved while output stalled");

    a_no_dz_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        adv && dv && (side_out.kind == vrp_pkg::KIND_YAW || side_out.kind == vrp_pkg::KIND_ROTATE)
        |=> !depth_zero)
        else $error("depth flag on a non-projection word");
`endif

endmodule
